/* hw/rtl/dnt_pkg.sv */
// ----------------------------------------------------------------------------
// dnt_pkg
// shared types, codes and defaults of the directory name table
// ----------------------------------------------------------------------------
package dnt_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int NAME_BYTES_DEF = 8;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] file_name;
    logic [9:0]  header_sector;
    logic        is_directory;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] found_sector;
    logic       found_directory;
    logic [5:0] entry_index;
  } out_item_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic        active;
    logic [63:0] key;
    logic        hit;
    logic        free;
    logic [9:0]  sector;
    logic        dir;
  } tok_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SET,
    WR_CLR
  } wr_op_t;

  typedef struct packed {
    wr_op_t      op;
    logic [63:0] name;
    logic [9:0]  sector;
    logic        dir;
  } wr_cmd_t;

endpackage

/* hw/rtl/dnt_cell.sv */
// ----------------------------------------------------------------------------
// dnt_cell
// one table entry: compares the passing token and takes write commands
// ----------------------------------------------------------------------------
module dnt_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dnt_pkg::tok_t      tok_i,
  input  logic [IDX_W-1:0]   hit_idx_i,
  input  logic [IDX_W-1:0]   free_idx_i,
  output dnt_pkg::tok_t      tok_o,
  output logic [IDX_W-1:0]   hit_idx_o,
  output logic [IDX_W-1:0]   free_idx_o,
  input  dnt_pkg::wr_cmd_t   wr_i,
  input  logic [IDX_W-1:0]   wr_idx_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic              valid_r;
  logic [63:0]       name_r;
  logic [9:0]        sector_r;
  logic              dir_r;
  dnt_pkg::tok_t     tok_r;
  dnt_pkg::tok_t     tok_nxt;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [IDX_W-1:0]  hit_idx_nxt;
  logic [IDX_W-1:0]  free_idx_r;
  logic [IDX_W-1:0]  free_idx_nxt;

  always_comb begin
    tok_nxt      = tok_i;
    hit_idx_nxt  = hit_idx_i;
    free_idx_nxt = free_idx_i;
    if (tok_i.active && !tok_i.hit && valid_r && (name_r == tok_i.key)) begin
      tok_nxt.hit    = 1'b1;
      tok_nxt.sector = sector_r;
      tok_nxt.dir    = dir_r;
      hit_idx_nxt    = MY_IDX;
    end
    if (tok_i.active && !tok_i.free && !valid_r) begin
      tok_nxt.free = 1'b1;
      free_idx_nxt = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      unique case (wr_i.op)
        dnt_pkg::WR_SET: begin
          if (wr_idx_i == MY_IDX) begin
            valid_r  <= 1'b1;
            name_r   <= wr_i.name;
            sector_r <= wr_i.sector;
            dir_r    <= wr_i.dir;
          end
        end
        dnt_pkg::WR_CLR: begin
          if (wr_idx_i == MY_IDX) begin
            valid_r <= 1'b0;
          end
        end
        dnt_pkg::WR_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign tok_o      = tok_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;

endmodule

/* hw/rtl/dnt_ctrl.sv */
// ----------------------------------------------------------------------------
// dnt_ctrl
// item sequencer: launches the search token, decides and issues the update
// ----------------------------------------------------------------------------
module dnt_ctrl #(
  parameter int IDX_W      = 6,
  parameter int NAME_BYTES = dnt_pkg::NAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dnt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dnt_pkg::out_item_t  out_item,
  output dnt_pkg::tok_t       tok_o,
  input  dnt_pkg::tok_t       tail_tok_i,
  input  logic [IDX_W-1:0]    tail_hit_idx_i,
  input  logic [IDX_W-1:0]    tail_free_idx_i,
  output dnt_pkg::wr_cmd_t    wr_o,
  output logic [IDX_W-1:0]    wr_idx_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic                out_valid_r;
  dnt_pkg::out_item_t  out_item_r;
  dnt_pkg::tok_t       tok_r;
  dnt_pkg::wr_cmd_t    wr_r;
  logic [IDX_W-1:0]    wr_idx_r;
  logic [1:0]          mode_r;
  logic [9:0]          sector_r;
  logic                dir_r;
  dnt_pkg::tok_t       fin_tok_r;
  logic [IDX_W-1:0]    fin_hit_idx_r;
  logic [IDX_W-1:0]    fin_free_idx_r;

  dnt_pkg::out_item_t  res_nxt;
  dnt_pkg::wr_cmd_t    wr_nxt;
  logic [IDX_W-1:0]    wr_idx_nxt;
  logic [IDX_W+5:0]    hit_ext;
  logic [IDX_W+5:0]    free_ext;

  // name ends at its first zero byte or at NAME_BYTES
  function automatic logic [63:0] canon_name(input logic [63:0] raw);
    logic [63:0] res;
    logic        ended;
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if ((raw[8*k +: 8] == 8'd0) || (k >= NAME_BYTES)) ended = 1'b1;
      if (!ended) res[8*k +: 8] = raw[8*k +: 8];
    end
    return res;
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign hit_ext  = {6'd0, fin_hit_idx_r};
  assign free_ext = {6'd0, fin_free_idx_r};

  always_comb begin
    res_nxt        = '0;
    res_nxt.status = dnt_pkg::ST_NOT_FOUND;
    wr_nxt.op      = dnt_pkg::WR_NONE;
    wr_nxt.name    = fin_tok_r.key;
    wr_nxt.sector  = sector_r;
    wr_nxt.dir     = dir_r;
    wr_idx_nxt     = fin_hit_idx_r;
    unique case (mode_r)
      dnt_pkg::MODE_LOOKUP: begin
        if (fin_tok_r.hit) begin
          res_nxt.status          = dnt_pkg::ST_OK;
          res_nxt.found_sector    = fin_tok_r.sector;
          res_nxt.found_directory = fin_tok_r.dir;
          res_nxt.entry_index     = hit_ext[5:0];
        end
      end
      dnt_pkg::MODE_ADD: begin
        priority if (fin_tok_r.hit) begin
          res_nxt.status      = dnt_pkg::ST_DUPLICATE;
          res_nxt.entry_index = hit_ext[5:0];
        end else if (fin_tok_r.free) begin
          res_nxt.status      = dnt_pkg::ST_OK;
          res_nxt.entry_index = free_ext[5:0];
          wr_nxt.op           = dnt_pkg::WR_SET;
          wr_idx_nxt          = fin_free_idx_r;
        end else begin
          res_nxt.status = dnt_pkg::ST_FULL;
        end
      end
      dnt_pkg::MODE_REMOVE: begin
        if (fin_tok_r.hit) begin
          res_nxt.status      = dnt_pkg::ST_OK;
          res_nxt.entry_index = hit_ext[5:0];
          wr_nxt.op           = dnt_pkg::WR_CLR;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      tok_r.active <= 1'b0;
      wr_r.op      <= dnt_pkg::WR_NONE;
    end else begin
      tok_r.active <= 1'b0;
      wr_r.op      <= dnt_pkg::WR_NONE;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            tok_r.active <= 1'b1;
            tok_r.key    <= canon_name(in_item.file_name);
            tok_r.hit    <= 1'b0;
            tok_r.free   <= 1'b0;
            tok_r.sector <= '0;
            tok_r.dir    <= 1'b0;
            mode_r       <= in_item.mode;
            sector_r     <= in_item.header_sector;
            dir_r        <= in_item.is_directory;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail_tok_i.active) begin
            fin_tok_r      <= tail_tok_i;
            fin_hit_idx_r  <= tail_hit_idx_i;
            fin_free_idx_r <= tail_free_idx_i;
            state_r        <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_item_r  <= res_nxt;
            wr_r        <= wr_nxt;
            wr_idx_r    <= wr_idx_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign tok_o     = tok_r;
  assign wr_o      = wr_r;
  assign wr_idx_o  = wr_idx_r;

  a_tail_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail_tok_i.active |-> (state_r == ST_SCAN))
    else $error("search token left the chain outside a scan");

  a_wr_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r.op != dnt_pkg::WR_NONE) |=> (wr_r.op == dnt_pkg::WR_NONE))
    else $error("update command held for more than one cycle");

  a_set_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r.op == dnt_pkg::WR_SET) |-> (out_valid_r && (out_item_r.status == dnt_pkg::ST_OK)))
    else $error("entry filled without an ok result");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

/* hw/rtl/directory_name_table_unit.sv */
// ----------------------------------------------------------------------------
// directory_name_table_unit
// name keyed directory table built as a row of entry cells
// ----------------------------------------------------------------------------
// items are taken one at a time: a new item is accepted only once the last one's result
// has entered the output register; the search token steps through one entry cell per
//   cycle, then the controller writes the update back
// the next item is taken while a result still waits in the output register
// reset: synchronous active-low rst_n clears all entry valid bits at once
// ----------------------------------------------------------------------------
module directory_name_table_unit #(
  parameter int ENTRIES    = dnt_pkg::ENTRIES_DEF,
  parameter int NAME_BYTES = dnt_pkg::NAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dnt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dnt_pkg::out_item_t  out_item
);

  localparam int IDX_W = $clog2(ENTRIES);

  dnt_pkg::tok_t     tok_a      [ENTRIES+1];
  logic [IDX_W-1:0]  hit_idx_a  [ENTRIES+1];
  logic [IDX_W-1:0]  free_idx_a [ENTRIES+1];
  dnt_pkg::wr_cmd_t  wr;
  logic [IDX_W-1:0]  wr_idx;

  assign hit_idx_a[0]  = '0;
  assign free_idx_a[0] = '0;

  dnt_ctrl #(
    .IDX_W      (IDX_W),
    .NAME_BYTES (NAME_BYTES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .tok_o           (tok_a[0]),
    .tail_tok_i      (tok_a[ENTRIES]),
    .tail_hit_idx_i  (hit_idx_a[ENTRIES]),
    .tail_free_idx_i (free_idx_a[ENTRIES]),
    .wr_o            (wr),
    .wr_idx_o        (wr_idx)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dnt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok_a[i]),
      .hit_idx_i  (hit_idx_a[i]),
      .free_idx_i (free_idx_a[i]),
      .tok_o      (tok_a[i+1]),
      .hit_idx_o  (hit_idx_a[i+1]),
      .free_idx_o (free_idx_a[i+1]),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx)
    );
  end

endmodule
